// File: sv/aacs_pkg.sv
// ----------------------------------------------------------------------------
// aacs_pkg: shared constants and types for the autoranging channel scanner
// Register indexes, widths and reset values of the correction registers.
// ----------------------------------------------------------------------------
package aacs_pkg;

    localparam int CHANNELS_DEF        = 4;
    localparam int COUNT_BITS_DEF      = 16;
    localparam int FULL_SCALE_CODE_DEF = 32767;

    localparam int SUM_W     = 40;
    localparam int AVG_W     = 21;
    localparam int REG_W     = 24;
    localparam int SAMPLE_W  = 16;
    localparam int RANGE_W   = 3;
    localparam int OUT_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int REPORT_CH = 4;

    localparam logic [RANGE_W-1:0] RANGE_MAX = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SLOPE0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET0 = 3'd4;

    localparam logic [REG_W-1:0] SLOPE_RST [4] = '{
        24'sd305397, 24'sd666251, 24'sd155447, 24'sd1986134};
    localparam logic [REG_W-1:0] OFFSET_RST [4] = '{
        -24'sd191, -24'sd17049, 24'sd4228, 24'sd16066};

    typedef enum logic {KIND_SAMPLE = 1'b0, KIND_CLOSE = 1'b1} t_kind;

endpackage

// File: sv/aacs_ram.sv
// ----------------------------------------------------------------------------
// aacs_ram: generic single-port-write, single-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module aacs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: sv/autoranging_adc_channel_scanner.sv
// Sample item: read, latch, write back and read the next range, settle, present;
// the present step waits while the output register is still held. Window close:
// bit-serial division of each channel, one quotient bit per cycle (skipped for an
// empty channel), then read, multiply, add and present for each reported value,
// four at most, plus any output stall. One item at a time. Reset clears control
// state and registers; the channel memory, ranges included, is then swept clear.
// ----------------------------------------------------------------------------
// autoranging_adc_channel_scanner: round-robin autoranging channel scanner
// Channel state lives in one RAM; sums are averaged and line-corrected.
// ----------------------------------------------------------------------------
module autoranging_adc_channel_scanner
    import aacs_pkg::*;
#(
    parameter int CHANNELS        = CHANNELS_DEF,
    parameter int COUNT_BITS      = COUNT_BITS_DEF,
    parameter int FULL_SCALE_CODE = FULL_SCALE_CODE_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_kind,
    input  logic signed [SAMPLE_W-1:0] i_raw_sample,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic                       o_result_kind,
    output logic [1:0]                 o_channel,
    output logic [RANGE_W-1:0]         o_gain_step,
    output logic                       o_round_done,
    output logic signed [OUT_W-1:0]    o_corrected_value,
    output logic                       o_last,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [REG_W-1:0]           i_cfg_data
);
    localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ENT_W   = RANGE_W + SUM_W + COUNT_BITS + AVG_W;
    localparam int HYST    = FULL_SCALE_CODE / 50;
    localparam int HI_TH   = FULL_SCALE_CODE - HYST;
    localparam int LO_TH   = FULL_SCALE_CODE / 2 - HYST;
    localparam int NREP    = (CHANNELS < REPORT_CH) ? CHANNELS : REPORT_CH;
    localparam int DIV_W   = SUM_W;
    localparam int PROD_W  = REG_W + AVG_W;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
    localparam logic signed [SUM_W-1:0] SMAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SMIN = {1'b1, {(SUM_W-1){1'b0}}};

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD, S_UPD, S_NRD, S_NXT, S_OUT,
        S_CRD, S_CDIV0, S_CDIV, S_CWR, S_RRD, S_RMUL, S_RADD, S_ROUT
    } t_state;

    t_state                   r_state;
    logic [CH_W-1:0]          r_cur, r_ch;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic [REG_W-1:0]         r_slope [4];
    logic [REG_W-1:0]         r_offset [4];
    logic                     r_we;
    logic [CH_W-1:0]          r_waddr;
    logic [ENT_W-1:0]         r_wdata;
    logic [CH_W-1:0]          r_raddr;
    logic [ENT_W-1:0]         w_rdata;
    logic [ENT_W-1:0]         r_ent;
    // divider
    logic [DIV_W-1:0]         r_quo, r_rem, r_dvs;
    logic                     r_neg;
    logic [$clog2(DIV_W+1)-1:0] r_bit;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [OUT_W+1:0]  r_sumv;
    // output register
    logic                     r_ovalid, r_okind, r_oround, r_olast;
    logic [1:0]               r_och;
    logic [RANGE_W-1:0]       r_ogain;
    logic signed [OUT_W-1:0]  r_oval;

    aacs_ram #(.WIDTH(ENT_W), .DEPTH(1 << CH_W)) u_ram (
        .i_clk  (i_clk),
        .i_we   (r_we),
        .i_waddr(r_waddr),
        .i_wdata(r_wdata),
        .i_raddr(r_raddr),
        .o_rdata(w_rdata)
    );

    // entry fields
    logic [RANGE_W-1:0]       e_rng;
    logic signed [SUM_W-1:0]  e_sum;
    logic [COUNT_BITS-1:0]    e_cnt;
    logic signed [AVG_W-1:0]  e_avg;
    assign {e_rng, e_sum, e_cnt, e_avg} = r_ent;

    // sample update
    logic signed [SUM_W+1:0]  w_add;
    logic signed [SUM_W-1:0]  w_sum;
    logic [RANGE_W-1:0]       w_rng;
    logic [SAMPLE_W-1:0]      w_u;
    always_comb begin
        w_u   = r_sample;
        w_add = {{2{e_sum[SUM_W-1]}}, e_sum}
              + ((SUM_W+2)'(r_sample) <<< (RANGE_MAX - e_rng));
        if (w_add > (SUM_W+2)'(SMAX)) begin
            w_sum = SMAX;
        end else if (w_add < $signed({{2{1'b1}}, SMIN})) begin
            w_sum = SMIN;
        end else begin
            w_sum = w_add[SUM_W-1:0];
        end
        w_rng = e_rng;
        if (32'(w_u) > 32'(HI_TH) && e_rng > 0) begin
            w_rng = e_rng - 1'b1;
        end else if (32'(w_u) < 32'(LO_TH) && e_rng < RANGE_MAX) begin
            w_rng = e_rng + 1'b1;
        end
    end

    // restoring divide step on magnitudes
    logic [DIV_W:0]   w_trial;
    logic [DIV_W-1:0] w_remsh;
    always_comb begin
        w_remsh = {r_rem[DIV_W-2:0], r_quo[DIV_W-1]};
        w_trial = {1'b0, w_remsh} - {1'b0, r_dvs};
    end

    // correction rounding and saturation
    logic signed [PROD_W-1:0] w_shr;
    logic signed [OUT_W-1:0]  w_sat;
    assign w_shr = (r_prod + PROD_W'(32768)) >>> 16;
    always_comb begin
        if (r_sumv > $signed((OUT_W+2)'({1'b0, {(OUT_W-1){1'b1}}}))) begin
            w_sat = {1'b0, {(OUT_W-1){1'b1}}};
        end else if (r_sumv < -((OUT_W+2)'(1) <<< (OUT_W-1))) begin
            w_sat = {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
            w_sat = r_sumv[OUT_W-1:0];
        end
    end

    logic [CH_W-1:0] w_nxt;
    assign w_nxt = (r_cur == CH_W'(CHANNELS - 1)) ? '0 : r_cur + 1'b1;

    assign o_ready           = (r_state == S_IDLE);
    assign o_valid           = r_ovalid;
    assign o_result_kind     = r_okind;
    assign o_channel         = r_och;
    assign o_gain_step       = r_ogain;
    assign o_round_done      = r_oround;
    assign o_corrected_value = r_oval;
    assign o_last            = r_olast;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_slope[k]  <= SLOPE_RST[k];
                r_offset[k] <= OFFSET_RST[k];
            end
        end else if (i_cfg_we) begin
            if (i_cfg_index < REG_OFFSET0) begin
                r_slope[i_cfg_index[1:0]] <= i_cfg_data;
            end else begin
                r_offset[i_cfg_index[1:0]] <= i_cfg_data;
            end
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_cur    <= '0;
            r_ch     <= '0;
            r_we     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_we <= 1'b0;
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_we    <= 1'b1;
                    r_waddr <= r_ch;
                    r_wdata <= '0;
                    r_ch    <= r_ch + 1'b1;
                    if (r_ch == CH_W'((1 << CH_W) - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_sample <= i_raw_sample;
                        r_ch     <= '0;
                        r_raddr  <= (i_kind == KIND_CLOSE) ? '0 : r_cur;
                        r_state  <= (i_kind == KIND_CLOSE) ? S_CRD : S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    r_ent   <= w_rdata;
                    r_state <= S_NRD;
                end
                S_NRD: begin
                    // write back, then read the next channel's range
                    r_we    <= 1'b1;
                    r_waddr <= r_cur;
                    if (e_cnt < CNT_MAX) begin
                        r_wdata <= {w_rng, w_sum, e_cnt + 1'b1, e_avg};
                    end else begin
                        r_wdata <= {w_rng, e_sum, e_cnt, e_avg};
                    end
                    r_raddr <= w_nxt;
                    r_cur   <= w_nxt;
                    r_state <= S_NXT;
                end
                S_NXT: begin
                    // a single channel would read its old entry, so S_OUT uses the write data
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid) begin
                        r_ovalid <= 1'b1;
                        r_okind  <= KIND_SAMPLE;
                        r_och    <= 2'(r_cur);
                        r_ogain  <= (CHANNELS == 1) ? r_wdata[ENT_W-1 -: RANGE_W]
                                                    : w_rdata[ENT_W-1 -: RANGE_W];
                        r_oround <= (r_cur == '0);
                        r_oval   <= '0;
                        r_olast  <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                S_CRD: begin
                    r_state <= S_CDIV0;
                end
                S_CDIV0: begin
                    r_ent   <= w_rdata;
                    r_neg   <= w_rdata[ENT_W-RANGE_W-1];
                    r_quo   <= w_rdata[ENT_W-RANGE_W-1]
                             ? -w_rdata[ENT_W-RANGE_W-1 -: SUM_W]
                             : w_rdata[ENT_W-RANGE_W-1 -: SUM_W];
                    r_rem   <= '0;
                    r_dvs   <= DIV_W'(w_rdata[AVG_W +: COUNT_BITS]);
                    r_bit   <= '0;
                    r_state <= (w_rdata[AVG_W +: COUNT_BITS] == '0) ? S_CWR : S_CDIV;
                end
                S_CDIV: begin
                    if (w_trial[DIV_W]) begin
                        r_rem <= w_remsh;
                        r_quo <= {r_quo[DIV_W-2:0], 1'b0};
                    end else begin
                        r_rem <= w_trial[DIV_W-1:0];
                        r_quo <= {r_quo[DIV_W-2:0], 1'b1};
                    end
                    r_bit <= r_bit + 1'b1;
                    if (r_bit == ($bits(r_bit))'(DIV_W - 1)) begin
                        r_state <= S_CWR;
                    end
                end
                S_CWR: begin
                    r_we    <= 1'b1;
                    r_waddr <= r_ch;
                    if (e_cnt != '0) begin
                        r_wdata <= {e_rng, {SUM_W{1'b0}}, {COUNT_BITS{1'b0}},
                                    r_neg ? -r_quo[AVG_W-1:0] : r_quo[AVG_W-1:0]};
                    end else begin
                        r_wdata <= r_ent;
                    end
                    if (r_ch == CH_W'(CHANNELS - 1)) begin
                        r_ch    <= '0;
                        r_raddr <= '0;
                        r_state <= S_RRD;
                    end else begin
                        r_ch    <= r_ch + 1'b1;
                        r_raddr <= r_ch + 1'b1;
                        r_state <= S_CRD;
                    end
                end
                S_RRD: begin
                    // wait out the write of the last channel and the read
                    r_state <= S_RMUL;
                end
                S_RMUL: begin
                    if (r_we) begin
                        r_state <= S_RMUL;
                    end else begin
                        r_ent   <= w_rdata;
                        r_prod  <= $signed(r_slope[r_ch[1:0]])
                                 * $signed(w_rdata[AVG_W-1:0]);
                        r_state <= S_RADD;
                    end
                end
                S_RADD: begin
                    r_sumv  <= (OUT_W+2)'(w_shr) + (OUT_W+2)'($signed(r_offset[r_ch[1:0]]));
                    r_state <= S_ROUT;
                end
                S_ROUT: begin
                    if (!r_ovalid) begin
                        r_ovalid <= 1'b1;
                        r_okind  <= KIND_CLOSE;
                        r_och    <= 2'(r_ch);
                        r_ogain  <= e_rng;
                        r_oround <= 1'b0;
                        r_oval   <= w_sat;
                        r_olast  <= (r_ch == CH_W'(NREP - 1));
                        if (r_ch == CH_W'(NREP - 1)) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_ch    <= r_ch + 1'b1;
                            r_raddr <= r_ch + 1'b1;
                            r_state <= S_RRD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> (r_state == S_IDLE)) else $error("ready outside idle");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_corrected_value)))
        else $error("result dropped");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready) else $error("second item taken");
    a_sample_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result_kind) |-> (o_last && o_corrected_value == '0))
        else $error("sample result fields");
`endif
endmodule
